### rtl/core/hmr_pkg.sv
package hmr_pkg;

   localparam int LenWidth = 13;
   localparam int CmdWidth = 7;
   localparam int ChanWidth = 32;

   localparam logic [LenWidth-1:0] CapacityReset = 13'd7609;
   localparam logic [CmdWidth-1:0] KeepaliveReset = 7'd59;

   localparam logic OpArm = 1'b0;
   localparam logic OpByte = 1'b1;

   localparam logic [2:0] ErrNone = 3'd0;
   localparam logic [2:0] ErrCommand = 3'd1;
   localparam logic [2:0] ErrMaximum = 3'd2;
   localparam logic [2:0] ErrCapacity = 3'd3;
   localparam logic [2:0] ErrChannel = 3'd4;
   localparam logic [2:0] ErrSequence = 3'd5;

   localparam logic [1:0] RegChannelId = 2'd0;
   localparam logic [1:0] RegExpectedCommand = 2'd1;
   localparam logic [1:0] RegResponseCapacity = 2'd2;
   localparam logic [1:0] RegKeepaliveCommand = 2'd3;

   typedef enum logic [2:0] {
      PhIdle,
      PhWait,
      PhInit,
      PhCont,
      PhDone,
      PhFail
   } phase_type;

   typedef struct packed {
      logic [ChanWidth-1:0] channel_id;
      logic [CmdWidth-1:0]  expected_command;
      logic [LenWidth-1:0]  response_capacity;
      logic [CmdWidth-1:0]  keepalive_command;
   } cfg_type;

   typedef struct packed {
      logic [7:0]          payload_byte;
      logic                payload_valid;
      logic                last_byte;
      logic                done_res;
      logic                failed;
      logic [2:0]          error_code;
      logic [LenWidth-1:0] message_length;
   } result_type;

endpackage

### rtl/core/hmr_req_if.sv
interface hmr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### rtl/core/hmr_rsp_if.sv
interface hmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        last_byte;
   logic        done_res;
   logic        failed;
   logic [2:0]  error_code;
   logic [12:0] message_length;

   modport source (
      output valid, output payload_byte, output payload_valid, output last_byte,
      output done_res, output failed, output error_code, output message_length,
      input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input last_byte,
      input done_res, input failed, input error_code, input message_length,
      output ready
   );
endinterface

### rtl/core/hmr_csr.sv
module hmr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output hmr_pkg::cfg_type cfg
);
   import hmr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign wr_en = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            RegChannelId:        cfg_in.channel_id = pwdata;
            RegExpectedCommand:  cfg_in.expected_command = pwdata[CmdWidth-1:0];
            RegResponseCapacity: cfg_in.response_capacity = pwdata[LenWidth-1:0];
            RegKeepaliveCommand: cfg_in.keepalive_command = pwdata[CmdWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_id <= '0;
         cfg_ff.expected_command <= '0;
         cfg_ff.response_capacity <= CapacityReset;
         cfg_ff.keepalive_command <= KeepaliveReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         RegChannelId:        prdata = cfg_ff.channel_id;
         RegExpectedCommand:  prdata = {25'd0, cfg_ff.expected_command};
         RegResponseCapacity: prdata = {19'd0, cfg_ff.response_capacity};
         RegKeepaliveCommand: prdata = {25'd0, cfg_ff.keepalive_command};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/hmr_core.sv
module hmr_core #(
   parameter int PACKET_BYTES = 64,
   parameter int MAX_MESSAGE = 7609
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat,
   input  logic                opcode,
   input  logic [7:0]          rx_byte,
   input  hmr_pkg::cfg_type    cfg,
   output hmr_pkg::result_type result
);
   import hmr_pkg::*;

   localparam int PosWidth = $clog2(PACKET_BYTES);
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(PACKET_BYTES - 1);
   localparam logic [PosWidth-1:0] PosCommand = PosWidth'(4);
   localparam logic [PosWidth-1:0] PosLenHigh = PosWidth'(5);
   localparam logic [PosWidth-1:0] PosLenLow = PosWidth'(6);
   localparam logic [PosWidth-1:0] PosInitData = PosWidth'(7);
   localparam logic [15:0] MaxLen = 16'(MAX_MESSAGE);

   phase_type            phase_ff, phase_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [ChanWidth-1:0] chan_ff, chan_in;
   logic [CmdWidth-1:0]  cmd_ff, cmd_in;
   logic [7:0]           len_high_ff, len_high_in;
   logic [LenWidth-1:0]  exp_len_ff, exp_len_in;
   logic [LenWidth-1:0]  copied_ff, copied_in;
   logic [7:0]           seq_ff, seq_in;
   logic                 skip_ff, skip_in;
   logic [15:0]          len16;
   logic [LenWidth-1:0]  copied_inc;
   logic                 active;

   assign len16 = {len_high_ff, rx_byte};
   assign copied_inc = copied_ff + LenWidth'(1);
   assign active = (phase_ff == PhWait) || (phase_ff == PhInit) || (phase_ff == PhCont);

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      chan_in = chan_ff;
      cmd_in = cmd_ff;
      len_high_in = len_high_ff;
      exp_len_in = exp_len_ff;
      copied_in = copied_ff;
      seq_in = seq_ff;
      skip_in = skip_ff;
      result = '0;
      if (opcode == OpArm) begin
         phase_in = PhWait;
         pos_in = '0;
         chan_in = '0;
         cmd_in = '0;
         len_high_in = '0;
         exp_len_in = '0;
         copied_in = '0;
         seq_in = '0;
         skip_in = 1'b0;
      end else if (active) begin
         if (pos_ff < PosCommand) begin
            chan_in = {chan_ff[ChanWidth-9:0], rx_byte};
         end else if (phase_ff == PhWait && !skip_ff) begin
            if (pos_ff == PosCommand) begin
               cmd_in = rx_byte[CmdWidth-1:0];
               if (!rx_byte[7] || chan_ff != cfg.channel_id ||
                   rx_byte[CmdWidth-1:0] == cfg.keepalive_command) begin
                  skip_in = 1'b1;
               end
            end else if (pos_ff == PosLenHigh) begin
               len_high_in = rx_byte;
            end else if (pos_ff == PosLenLow) begin
               priority if (cmd_ff != cfg.expected_command) begin
                  phase_in = PhFail;
                  result.failed = 1'b1;
                  result.error_code = ErrCommand;
               end else if (len16 > MaxLen) begin
                  phase_in = PhFail;
                  result.failed = 1'b1;
                  result.error_code = ErrMaximum;
               end else if (len16 > {3'd0, cfg.response_capacity}) begin
                  phase_in = PhFail;
                  result.failed = 1'b1;
                  result.error_code = ErrCapacity;
               end else begin
                  exp_len_in = len16[LenWidth-1:0];
                  copied_in = '0;
                  if (len16 == 16'd0) begin
                     result.last_byte = 1'b1;
                     result.done_res = 1'b1;
                     phase_in = PhDone;
                  end else begin
                     phase_in = PhInit;
                  end
               end
            end
         end else if ((phase_ff == PhInit && pos_ff >= PosInitData) ||
                      (phase_ff == PhCont && pos_ff > PosCommand)) begin
            result.payload_byte = rx_byte;
            result.payload_valid = 1'b1;
            copied_in = copied_inc;
            if (copied_inc >= exp_len_ff) begin
               result.last_byte = 1'b1;
               result.done_res = 1'b1;
               result.message_length = exp_len_ff;
               phase_in = PhDone;
            end
         end else if (phase_ff == PhCont && pos_ff == PosCommand) begin
            priority if (chan_ff != cfg.channel_id) begin
               phase_in = PhFail;
               result.failed = 1'b1;
               result.error_code = ErrChannel;
            end else if (rx_byte != seq_ff) begin
               phase_in = PhFail;
               result.failed = 1'b1;
               result.error_code = ErrSequence;
            end else begin
               seq_in = seq_ff + 8'd1;
            end
         end
         if (pos_ff == LastPos) begin
            pos_in = '0;
            skip_in = 1'b0;
            chan_in = '0;
            if (phase_in == PhInit) begin
               phase_in = PhCont;
            end
         end else begin
            pos_in = pos_ff + PosWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         pos_ff <= '0;
         chan_ff <= '0;
         cmd_ff <= '0;
         len_high_ff <= '0;
         exp_len_ff <= '0;
         copied_ff <= '0;
         seq_ff <= '0;
         skip_ff <= 1'b0;
      end else if (beat) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         chan_ff <= chan_in;
         cmd_ff <= cmd_in;
         len_high_ff <= len_high_in;
         exp_len_ff <= exp_len_in;
         copied_ff <= copied_in;
         seq_ff <= seq_in;
         skip_ff <= skip_in;
      end
   end

`ifndef ASSERT_OFF
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      beat && result.done_res |=> phase_ff == PhDone)
      else $error("completion did not move to done");
   a_fail_phase: assert property (@(posedge clock) disable iff (reset)
      beat && result.failed |=> phase_ff == PhFail && $past(result.error_code) != ErrNone)
      else $error("failure without code or fail phase");
   a_copied_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhInit || phase_ff == PhCont |-> copied_ff < exp_len_ff)
      else $error("copied count passed announced length");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LastPos)
      else $error("byte position beyond packet");
`endif

endmodule

### rtl/core/hmr_out_reg.sv
module hmr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  hmr_pkg::result_type in_result,
   output logic                in_ready,
   output logic                out_valid,
   output hmr_pkg::result_type out_result,
   input  logic                out_ready
);
   import hmr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_result;
      end
   end

   assign out_valid = valid_ff;
   assign out_result = data_ff;

endmodule

### rtl/core/hid_message_reassembler.sv
// Rebuilds one HID message from report bytes, one byte per req beat, at a packet
// size of PACKET_BYTES. A beat with opcode 0 arms reception; bytes then wait for an
// initial packet on channel_id that is not a keepalive, check command and length,
// and stream payload bytes out, one rsp beat per req beat. The state update and result
// logic sit between the state registers and a single output register, so a new beat is
// taken each cycle unless a held result is stalled by rsp ready. Configure registers
// over the csr port only while idle.
module hid_message_reassembler #(
   parameter int PACKET_BYTES = 64,
   parameter int MAX_MESSAGE = 7609
) (
   input  logic        clock,
   input  logic        reset,
   hmr_req_if.sink     req_bus,
   hmr_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hmr_pkg::*;

   cfg_type    cfg;
   result_type core_result;
   result_type out_result;
   logic       beat;
   logic       in_ready;

   assign csr_pready = 1'b1;
   assign req_bus.ready = in_ready;
   assign beat = req_bus.valid && in_ready;

   hmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   hmr_core #(
      .PACKET_BYTES (PACKET_BYTES),
      .MAX_MESSAGE  (MAX_MESSAGE)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .opcode  (req_bus.opcode),
      .rx_byte (req_bus.rx_byte),
      .cfg     (cfg),
      .result  (core_result)
   );

   hmr_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_result  (core_result),
      .in_ready   (in_ready),
      .out_valid  (rsp_bus.valid),
      .out_result (out_result),
      .out_ready  (rsp_bus.ready)
   );

   assign rsp_bus.payload_byte = out_result.payload_byte;
   assign rsp_bus.payload_valid = out_result.payload_valid;
   assign rsp_bus.last_byte = out_result.last_byte;
   assign rsp_bus.done_res = out_result.done_res;
   assign rsp_bus.failed = out_result.failed;
   assign rsp_bus.error_code = out_result.error_code;
   assign rsp_bus.message_length = out_result.message_length;

endmodule
